[sv/sgwb_pkg.sv]
// ----------------------------------------------------------------------------
// sgwb_pkg
// Shared types, register codes, sequencer states and fixed-point helpers of
// the stereo gain, width and balance core.
// ----------------------------------------------------------------------------
package sgwb_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int RAMP_FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TGT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_TGT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TGT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LEN = 3'd5;

    // ramp slots
    localparam int N_RAMPS = 3;
    localparam logic [1:0] RAMP_GAIN  = 2'd0;
    localparam logic [1:0] RAMP_PAN   = 2'd1;
    localparam logic [1:0] RAMP_WIDTH = 2'd2;

    // target and length limits, reset values
    localparam int TGT_W = 17;
    localparam int LEN_W = 16;
    localparam logic signed [TGT_W-1:0] TGT_UMAX   = 17'sd32768;
    localparam logic signed [TGT_W-1:0] PAN_MAX    = 17'sd16384;
    localparam logic signed [TGT_W-1:0] UNITY_Q14  = 17'sd16384;
    localparam logic [LEN_W-1:0] GAIN_LEN_RST  = 16'd720;
    localparam logic [LEN_W-1:0] PAN_LEN_RST   = 16'd960;
    localparam logic [LEN_W-1:0] WIDTH_LEN_RST = 16'd1200;

    // fixed-point helper width
    localparam int RW = 72;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_SLD,
        S_SDIV,
        S_SDONE,
        S_ADV,
        S_XG,
        S_YG,
        S_SD,
        S_DW,
        S_MIX,
        S_WW,
        S_CLOAD,
        S_CDIV,
        S_SQLD,
        S_SQRT,
        S_PP,
        S_HLD,
        S_HMUL,
        S_HSUB,
        S_COS,
        S_LC,
        S_RC,
        S_LB,
        S_RB,
        S_OUT
    } t_state;

    // divide by 2^sh, round half away from zero
    function automatic logic signed [RW-1:0] rnd_sh(input logic signed [RW-1:0] v,
                                                    input int unsigned sh);
        logic [RW-1:0] mag;
        logic [RW-1:0] r;
        mag = v[RW-1] ? RW'(-v) : RW'(v);
        r   = (mag + (RW'(1) << (sh - 1))) >> sh;
        return v[RW-1] ? -signed'(r) : signed'(r);
    endfunction

    // cosine polynomial coefficients, Q30
    function automatic logic signed [33:0] cos_coef(input logic [2:0] k);
        logic signed [33:0] c;
        case (k)
            3'd0:    c = 34'sd1073741824;
            3'd1:    c = 34'sd1324675879;
            3'd2:    c = 34'sd272375560;
            3'd3:    c = 34'sd22401992;
            3'd4:    c = 34'sd987048;
            3'd5:    c = 34'sd27060;
            default: c = 34'sd0;
        endcase
        return c;
    endfunction

endpackage

[sv/sgwb_in_if.sv]
// ----------------------------------------------------------------------------
// sgwb_in_if
// Input sample channel: one stereo pair per request.
// ----------------------------------------------------------------------------
interface sgwb_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

[sv/sgwb_out_if.sv]
// ----------------------------------------------------------------------------
// sgwb_out_if
// Output sample channel: one processed stereo pair per request.
// ----------------------------------------------------------------------------
interface sgwb_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

[sv/stereo_gain_width_balance_core.sv]
// ----------------------------------------------------------------------------
// stereo_gain_width_balance_core
// Ramped gain, mid/side width with loudness compensation and cosine balance
// on one stereo pair, computed on a single shared multiplier and divider.
// ----------------------------------------------------------------------------
// A request runs from acceptance to the output register through the mix states
// alone when the pan is centred and the width is at most unity, adds five Horner
// steps on the shared multiplier when the pan is off centre, and adds a restoring
// divider followed by a square root when the width is above unity and differs
// from the last compensated width. A muted sample goes from the advance state
// straight to the output state. The next request is taken in the idle state after
// the output register is loaded, so no new pair is taken before the last is done.
// After a target write that starts a ramp, the input is held off while the same
// divider works out the step of each started ramp.
// A finished pair waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
module stereo_gain_width_balance_core #(
    parameter int SAMPLE_BITS    = sgwb_pkg::SAMPLE_BITS_DEF,
    parameter int RAMP_FRAC_BITS = sgwb_pkg::RAMP_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sgwb_in_if.sink                         i_in,
    sgwb_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sgwb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sgwb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sgwb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sgwb_pkg::*;

    localparam int NOW_W  = 17 + RAMP_FRAC_BITS;
    localparam int STEP_W = NOW_W + 1;
    localparam int DIFF_W = NOW_W + 1;
    localparam int NUM_W  = (DIFF_W > 62) ? DIFF_W : 62;
    localparam int DEN_W  = 31;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int SD_W   = SAMPLE_BITS + 2;
    localparam int LO_W   = SAMPLE_BITS + 4;
    localparam int MA_W   = (LO_W > 34) ? LO_W : 34;
    localparam int MB_W   = 32;
    localparam int P_W    = MA_W + MB_W;
    localparam int SQ_IT  = 16;
    localparam logic signed [NOW_W-1:0] MUTE_LIMIT =
        NOW_W'((64'(1) << (14 + RAMP_FRAC_BITS)) / 1000000);
    localparam logic signed [LO_W-1:0] SAT_HI =
        LO_W'((64'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [LO_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic [16:0] Q16_ONE = 17'd65536;

    // ramp state
    logic signed [TGT_W-1:0]  r_tgt  [N_RAMPS];
    logic        [LEN_W-1:0]  r_len  [N_RAMPS];
    logic signed [NOW_W-1:0]  r_now  [N_RAMPS];
    logic signed [STEP_W-1:0] r_step [N_RAMPS];
    logic        [LEN_W-1:0]  r_left [N_RAMPS];
    logic        [N_RAMPS-1:0] r_pend;

    // sequencer and datapath registers
    t_state                   r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_x, r_y;
    logic        [15:0]       r_g, r_w;
    logic signed [15:0]       r_p;
    logic signed [P_W-1:0]    r_prod;
    logic signed [SD_W-1:0]   r_gl, r_s, r_d;
    logic signed [LO_W-1:0]   r_lo, r_ro;
    logic        [16:0]       r_comp, r_cos;
    logic        [15:0]       r_cw;
    logic        [16:0]       r_ccomp;
    logic                     r_cw_ok;
    logic        [31:0]       r_u;
    logic signed [33:0]       r_hr;
    logic        [CNT_W-1:0]  r_cnt;
    logic        [NUM_W-1:0]  r_dv_num;
    logic        [DEN_W-1:0]  r_dv_rem, r_dv_den;
    logic        [1:0]        r_dv_idx;
    logic                     r_dv_neg;
    logic        [31:0]       r_sq_v, r_sq_res, r_sq_bit;
    logic                     r_ov;
    logic signed [SAMPLE_BITS-1:0] r_ol, r_or;

    // combinational signals
    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [P_W-1:0]    w_prod;
    logic                     w_in_rdy, w_acc, w_out_load, w_mute, w_comp_hit;
    logic        [1:0]        w_pick;
    logic                     w_last;
    logic        [DEN_W:0]    w_rem_sh;
    logic                     w_qbit;
    logic        [32:0]       w_trial;
    logic                     w_sq_take;
    logic signed [NOW_W-1:0]  w_adv [N_RAMPS];
    logic        [LEN_W-1:0]  w_adv_left [N_RAMPS];
    logic signed [NOW_W-1:0]  w_pan_adj;
    logic signed [SD_W-1:0]   w_gr;
    logic signed [RW-1:0]     w_mix_l, w_mix_r;
    logic        [16:0]       w_bl, w_br;
    logic signed [33:0]       w_cos_r;
    logic signed [LO_W-1:0]   w_rfin;
    logic signed [DIFF_W-1:0] w_diff;
    logic        [DIFF_W-1:0] w_diff_mag;
    logic                     w_cfg_we;
    logic        [CFG_IDX_W-1:0] w_cfg_idx;
    logic signed [TGT_W-1:0]  w_nt;
    logic        [1:0]        w_ci;
    logic signed [15:0]       w_pan_v;

    // ramp advance for the current sample
    always_comb begin
        for (int i = 0; i < N_RAMPS; i++) begin
            w_adv[i]      = r_now[i];
            w_adv_left[i] = r_left[i];
            if (r_left[i] != '0) begin
                w_adv_left[i] = r_left[i] - LEN_W'(1);
                if (w_adv_left[i] == '0) begin
                    w_adv[i] = NOW_W'(r_tgt[i]) <<< RAMP_FRAC_BITS;
                end else begin
                    w_adv[i] = NOW_W'(STEP_W'(r_now[i]) + r_step[i]);
                end
            end
        end
        w_pan_adj = w_adv[RAMP_PAN] +
            (w_adv[RAMP_PAN][NOW_W-1] ? NOW_W'((64'(1) << RAMP_FRAC_BITS) - 1) : '0);
    end

    assign w_mute = (r_tgt[RAMP_GAIN] <= TGT_W'(1)) && (r_left[RAMP_GAIN] == '0) &&
                    (r_now[RAMP_GAIN] <= MUTE_LIMIT);
    assign w_comp_hit = r_cw_ok && (r_cw == r_w);

    // lowest pending ramp step request
    always_comb begin
        w_pick = RAMP_GAIN;
        if (!r_pend[RAMP_GAIN]) begin
            w_pick = r_pend[RAMP_PAN] ? RAMP_PAN : RAMP_WIDTH;
        end
    end

    // shared restoring divider and square root steps
    assign w_rem_sh  = {r_dv_rem, r_dv_num[NUM_W-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_dv_den});
    assign w_trial   = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign w_sq_take = ({1'b0, r_sq_v} >= w_trial);
    assign w_last    = (r_cnt == CNT_W'(1));

    // shared multiplier
    assign w_prod = w_ma * w_mb;

    // misc datapath terms
    assign w_gr    = SD_W'(rnd_sh(RW'(r_prod), 14));
    assign w_mix_l = rnd_sh((RW'(r_s) <<< 14) + RW'(r_prod), 15);
    assign w_mix_r = rnd_sh((RW'(r_s) <<< 14) - RW'(r_prod), 15);
    assign w_bl    = (r_p > 16'sd0) ? r_cos : Q16_ONE;
    assign w_br    = (r_p < 16'sd0) ? r_cos : Q16_ONE;
    assign w_cos_r = (r_hr + 34'sd8192) >>> 14;
    assign w_rfin  = LO_W'(rnd_sh(RW'(r_prod), 16));
    assign w_diff  = DIFF_W'(NOW_W'(r_tgt[w_pick]) <<< RAMP_FRAC_BITS) -
                     DIFF_W'(r_now[w_pick]);
    assign w_diff_mag = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);

    // configuration decode and clamping
    assign w_cfg_we  = psel & penable & pwrite;
    assign w_cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign w_ci      = w_cfg_idx[1:0];
    assign w_pan_v   = signed'(pwdata[15:0]);
    always_comb begin
        if (w_cfg_idx == REG_PAN_TGT) begin
            if (w_pan_v > 16'sd16384) begin
                w_nt = PAN_MAX;
            end else if (w_pan_v < -16'sd16384) begin
                w_nt = -PAN_MAX;
            end else begin
                w_nt = TGT_W'(w_pan_v);
            end
        end else begin
            w_nt = (pwdata[15:0] > 16'd32768) ? TGT_W'(TGT_UMAX) :
                                                signed'({1'b0, pwdata[15:0]});
        end
    end

    // register read back
    assign pready = 1'b1;
    always_comb begin
        unique case (w_cfg_idx)
            REG_GAIN_TGT:  prdata = CFG_DATA_W'(r_tgt[RAMP_GAIN]);
            REG_PAN_TGT:   prdata = CFG_DATA_W'(r_tgt[RAMP_PAN]);
            REG_WIDTH_TGT: prdata = CFG_DATA_W'(r_tgt[RAMP_WIDTH]);
            REG_GAIN_LEN:  prdata = CFG_DATA_W'(r_len[RAMP_GAIN]);
            REG_PAN_LEN:   prdata = CFG_DATA_W'(r_len[RAMP_PAN]);
            REG_WIDTH_LEN: prdata = CFG_DATA_W'(r_len[RAMP_WIDTH]);
            default:       prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_pend != '0) begin
                    n_state = S_SLD;
                end else if (w_acc) begin
                    n_state = S_ADV;
                end
            end
            S_SLD:   n_state = S_SDIV;
            S_SDIV:  n_state = w_last ? S_SDONE : S_SDIV;
            S_SDONE: n_state = S_IDLE;
            S_ADV:   n_state = w_mute ? S_OUT : S_XG;
            S_XG:    n_state = S_YG;
            S_YG:    n_state = S_SD;
            S_SD:    n_state = S_DW;
            S_DW:    n_state = S_MIX;
            S_MIX: begin
                if (r_w > 16'd16384 && !w_comp_hit) begin
                    n_state = S_WW;
                end else if (r_p != 16'sd0) begin
                    n_state = S_PP;
                end else begin
                    n_state = S_LC;
                end
            end
            S_WW:    n_state = S_CLOAD;
            S_CLOAD: n_state = S_CDIV;
            S_CDIV:  n_state = w_last ? S_SQLD : S_CDIV;
            S_SQLD:  n_state = S_SQRT;
            S_SQRT: begin
                if (!w_last) begin
                    n_state = S_SQRT;
                end else if (r_p != 16'sd0) begin
                    n_state = S_PP;
                end else begin
                    n_state = S_LC;
                end
            end
            S_PP:    n_state = S_HLD;
            S_HLD:   n_state = S_HMUL;
            S_HMUL:  n_state = S_HSUB;
            S_HSUB:  n_state = (r_cnt == '0) ? S_COS : S_HMUL;
            S_COS:   n_state = S_LC;
            S_LC:    n_state = S_RC;
            S_RC:    n_state = S_LB;
            S_LB:    n_state = S_RB;
            S_RB:    n_state = S_OUT;
            S_OUT:   n_state = w_out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operand select
    always_comb begin
        w_in_rdy   = (r_state == S_IDLE) && (r_pend == '0);
        w_out_load = (r_state == S_OUT) && (!r_ov || o_out.ready);
        w_ma       = '0;
        w_mb       = '0;
        unique case (r_state)
            S_XG: begin
                w_ma = MA_W'(r_x);
                w_mb = signed'(MB_W'(r_g));
            end
            S_YG: begin
                w_ma = MA_W'(r_y);
                w_mb = signed'(MB_W'(r_g));
            end
            S_DW: begin
                w_ma = MA_W'(r_d);
                w_mb = signed'(MB_W'(r_w));
            end
            S_WW: begin
                w_ma = signed'(MA_W'(r_w));
                w_mb = signed'(MB_W'(r_w));
            end
            S_PP: begin
                w_ma = MA_W'(r_p);
                w_mb = MB_W'(r_p);
            end
            S_HMUL: begin
                w_ma = MA_W'(r_hr);
                w_mb = signed'(r_u);
            end
            S_LC: begin
                w_ma = MA_W'(r_lo);
                w_mb = signed'(MB_W'(r_comp));
            end
            S_RC: begin
                w_ma = MA_W'(r_ro);
                w_mb = signed'(MB_W'(r_comp));
            end
            S_LB: begin
                w_ma = MA_W'(r_lo);
                w_mb = signed'(MB_W'(w_bl));
            end
            S_RB: begin
                w_ma = MA_W'(r_ro);
                w_mb = signed'(MB_W'(w_br));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_acc       = i_in.valid & w_in_rdy;
    assign i_in.ready  = w_in_rdy;
    assign o_out.valid     = r_ov;
    assign o_out.left_out  = r_ol;
    assign o_out.right_out = r_or;

    // control state and ramp registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_ov    <= 1'b0;
            r_cw_ok <= 1'b0;
            r_tgt[RAMP_GAIN]  <= UNITY_Q14;
            r_tgt[RAMP_PAN]   <= '0;
            r_tgt[RAMP_WIDTH] <= UNITY_Q14;
            r_len[RAMP_GAIN]  <= GAIN_LEN_RST;
            r_len[RAMP_PAN]   <= PAN_LEN_RST;
            r_len[RAMP_WIDTH] <= WIDTH_LEN_RST;
            r_now[RAMP_GAIN]  <= NOW_W'(UNITY_Q14) <<< RAMP_FRAC_BITS;
            r_now[RAMP_PAN]   <= '0;
            r_now[RAMP_WIDTH] <= NOW_W'(UNITY_Q14) <<< RAMP_FRAC_BITS;
            for (int i = 0; i < N_RAMPS; i++) begin
                r_step[i] <= '0;
                r_left[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // output register
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            // ramp step division bookkeeping
            if (r_state == S_SLD) begin
                r_pend[w_pick] <= 1'b0;
            end
            if (r_state == S_SDONE) begin
                r_step[r_dv_idx] <= r_dv_neg ? -STEP_W'(r_dv_num[STEP_W-1:0]) :
                                               STEP_W'(r_dv_num[STEP_W-1:0]);
            end

            // per-sample ramp advance
            if (r_state == S_ADV && !w_mute) begin
                for (int i = 0; i < N_RAMPS; i++) begin
                    r_now[i]  <= w_adv[i];
                    r_left[i] <= w_adv_left[i];
                end
            end

            // compensation cache
            if (r_state == S_SQRT && w_last) begin
                r_cw_ok <= 1'b1;
            end

            // configuration writes
            if (w_cfg_we) begin
                if (w_cfg_idx == REG_GAIN_TGT || w_cfg_idx == REG_PAN_TGT ||
                    w_cfg_idx == REG_WIDTH_TGT) begin
                    if (w_nt != r_tgt[w_ci]) begin
                        r_tgt[w_ci] <= w_nt;
                        if (r_len[w_ci] == '0) begin
                            r_now[w_ci]  <= NOW_W'(w_nt) <<< RAMP_FRAC_BITS;
                            r_step[w_ci] <= '0;
                            r_left[w_ci] <= '0;
                            r_pend[w_ci] <= 1'b0;
                        end else begin
                            r_left[w_ci] <= r_len[w_ci];
                            r_pend[w_ci] <= 1'b1;
                        end
                    end
                end else if (w_cfg_idx == REG_GAIN_LEN) begin
                    r_len[RAMP_GAIN] <= pwdata[LEN_W-1:0];
                end else if (w_cfg_idx == REG_PAN_LEN) begin
                    r_len[RAMP_PAN] <= pwdata[LEN_W-1:0];
                end else if (w_cfg_idx == REG_WIDTH_LEN) begin
                    r_len[RAMP_WIDTH] <= pwdata[LEN_W-1:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // sample capture
        if (w_acc) begin
            r_x <= i_in.left_in;
            r_y <= i_in.right_in;
        end

        // product register for every multiply step
        if (r_state == S_XG || r_state == S_YG || r_state == S_DW ||
            r_state == S_WW || r_state == S_PP || r_state == S_HMUL ||
            r_state == S_LC || r_state == S_RC || r_state == S_LB || r_state == S_RB) begin
            r_prod <= w_prod;
        end

        case (r_state)
            // ramp step: |target - now| / samples
            S_SLD: begin
                r_dv_idx <= w_pick;
                r_dv_neg <= w_diff[DIFF_W-1];
                r_dv_num <= NUM_W'(w_diff_mag);
                r_dv_den <= DEN_W'(r_left[w_pick]);
                r_dv_rem <= '0;
                r_cnt    <= CNT_W'(NUM_W);
            end
            S_SDIV, S_CDIV: begin
                r_dv_rem <= w_qbit ? DEN_W'(w_rem_sh - {1'b0, r_dv_den}) : DEN_W'(w_rem_sh);
                r_dv_num <= {r_dv_num[NUM_W-2:0], w_qbit};
                r_cnt    <= r_cnt - CNT_W'(1);
            end
            // take the advanced gain, width and pan
            S_ADV: begin
                r_g <= w_adv[RAMP_GAIN][RAMP_FRAC_BITS +: 16];
                r_w <= w_adv[RAMP_WIDTH][RAMP_FRAC_BITS +: 16];
                r_p <= 16'(w_pan_adj >>> RAMP_FRAC_BITS);
                if (w_mute) begin
                    r_lo   <= '0;
                    r_prod <= '0;
                end
            end
            S_YG: r_gl <= SD_W'(rnd_sh(RW'(r_prod), 14));
            // mid and side sums
            S_SD: begin
                r_s <= r_gl + w_gr;
                r_d <= r_gl - w_gr;
            end
            // width mix and default compensation
            S_MIX: begin
                r_lo <= LO_W'(w_mix_l);
                r_ro <= LO_W'(w_mix_r);
                if (r_w <= 16'd16384) begin
                    r_comp <= Q16_ONE;
                end else begin
                    r_comp <= r_ccomp;
                end
            end
            // compensation: isqrt(2^61 / (2^28 + w^2))
            S_CLOAD: begin
                r_dv_num <= NUM_W'(1) << 61;
                r_dv_den <= DEN_W'(32'd268435456) + DEN_W'(r_prod[30:0]);
                r_dv_rem <= '0;
                r_cnt    <= CNT_W'(NUM_W);
            end
            S_SQLD: begin
                r_sq_v   <= r_dv_num[31:0];
                r_sq_res <= '0;
                r_sq_bit <= 32'd1 << 30;
                r_cnt    <= CNT_W'(SQ_IT);
            end
            S_SQRT: begin
                if (w_sq_take) begin
                    r_sq_v   <= r_sq_v - w_trial[31:0];
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_cnt    <= r_cnt - CNT_W'(1);
                if (w_last) begin
                    r_comp  <= w_sq_take ? 17'((r_sq_res >> 1) + r_sq_bit) :
                                           17'(r_sq_res >> 1);
                    r_ccomp <= w_sq_take ? 17'((r_sq_res >> 1) + r_sq_bit) :
                                           17'(r_sq_res >> 1);
                    r_cw    <= r_w;
                end
            end
            // balance cosine, Horner in Q30
            S_HLD: begin
                r_u   <= 32'(r_prod) << 2;
                r_hr  <= cos_coef(3'd5);
                r_cnt <= CNT_W'(4);
            end
            S_HSUB: begin
                r_hr <= cos_coef(r_cnt[2:0]) - 34'(r_prod >>> 30);
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            S_COS: begin
                if (r_hr < 0) begin
                    r_cos <= 17'd0;
                end else if (w_cos_r > 34'sd65536) begin
                    r_cos <= Q16_ONE;
                end else begin
                    r_cos <= 17'(w_cos_r);
                end
            end
            // compensation and balance rounding
            S_RC: r_lo <= w_rfin;
            S_LB: r_ro <= w_rfin;
            S_RB: r_lo <= w_rfin;
            // saturate into the output register
            S_OUT: begin
                if (w_out_load) begin
                    r_ol <= (r_lo > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                            (r_lo < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(r_lo);
                    r_or <= (w_rfin > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                            (w_rfin < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(w_rfin);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[tb/sgwb_tb_if.sv]
// ----------------------------------------------------------------------------
// sgwb_tb_if
// Testbench-side view of the channels: a packed stereo pair type only; the block's
// own interfaces are instantiated directly in the top module.
// ----------------------------------------------------------------------------
package sgwb_tb_pkg;

    // one stereo pair
    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } t_pair;

endpackage

[tb/tb_stereo_gain_width_balance_core.sv]
// ----------------------------------------------------------------------------
// tb_stereo_gain_width_balance_core
// Drives stereo pairs through the core under random stalls on both channels,
// rewrites the gain, pan, width and ramp registers between phases, and checks
// every output pair against a cycle-free model of ramps, width and balance.
// ----------------------------------------------------------------------------
module tb_stereo_gain_width_balance_core;
    import sgwb_pkg::*;
    import sgwb_tb_pkg::*;

    localparam int  RF = 16;
    localparam longint ONE_F = 64'sd1 << RF;
    localparam longint MUTE_LIM = (64'sd1 << 30) / 1000000;
    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    sgwb_in_if  #(.SAMPLE_BITS(24)) in_ch();
    sgwb_out_if #(.SAMPLE_BITS(24)) out_ch();

    stereo_gain_width_balance_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // model state
    longint tgt[3];
    longint rlen[3];
    longint cur[3];
    longint stp[3];
    longint cnt[3];

    t_pair pending_pairs[$];
    t_pair expected_pairs[$];
    int    errors = 0;
    int    n_checked = 0;
    longint cycles = 0;
    bit    calm = 1'b0;

    function automatic longint round_sh(longint v, int sh);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, b;
        res = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    // balance attenuation, Q16, for p in 0..16384
    function automatic longint balance_cos(longint p);
        longint c[6] = '{1073741824, 1324675879, 272375560, 22401992, 987048, 27060};
        longint t, u, r;
        t = p << 16;
        u = (t * t) >>> 30;
        r = c[5];
        for (int k = 4; k >= 0; k--) r = c[k] - ((r * u) >>> 30);
        if (r < 0) r = 0;
        r = (r + 8192) >>> 14;
        return r > 65536 ? 65536 : r;
    endfunction

    function automatic void model_reset();
        tgt  = '{16384, 0, 16384};
        rlen = '{720, 960, 1200};
        foreach (cur[i]) begin
            cur[i] = tgt[i] * ONE_F;
            stp[i] = 0;
            cnt[i] = 0;
        end
    endfunction

    // register write as seen by the block
    function automatic void model_write(int idx, logic [15:0] raw);
        longint v;
        int r;
        v = raw;
        if (idx >= 3) begin
            rlen[idx-3] = v;
            return;
        end
        r = idx;
        if (r == 1) begin
            if (v >= 32768) v -= 65536;
            if (v > 16384) v = 16384;
            if (v < -16384) v = -16384;
        end else if (v > 32768) begin
            v = 32768;
        end
        if (v == tgt[r]) return;
        tgt[r] = v;
        if (rlen[r] == 0) begin
            cur[r] = v * ONE_F;
            stp[r] = 0;
            cnt[r] = 0;
        end else begin
            cnt[r] = rlen[r];
            stp[r] = (v * ONE_F - cur[r]) / rlen[r];
        end
    endfunction

    function automatic void ramp_step(int r);
        if (cnt[r] != 0) begin
            cnt[r]--;
            if (cnt[r] == 0) cur[r] = tgt[r] * ONE_F;
            else cur[r] += stp[r];
        end
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // one processed pair
    function automatic t_pair process_pair(t_pair x);
        t_pair o;
        longint g, w, p, gl, gr, s, d, lo, ro, comp, bl, br;
        if (tgt[0] <= 1 && cnt[0] == 0 && cur[0] <= MUTE_LIM) begin
            o.left = '0;
            o.right = '0;
            return o;
        end
        ramp_step(0);
        ramp_step(2);
        ramp_step(1);
        g = cur[0] >>> RF;
        w = cur[2] >>> RF;
        p = cur[1] / ONE_F;
        gl = round_sh(longint'(x.left) * g, 14);
        gr = round_sh(longint'(x.right) * g, 14);
        s = gl + gr;
        d = gl - gr;
        lo = round_sh(s * 16384 + d * w, 15);
        ro = round_sh(s * 16384 - d * w, 15);
        comp = (w <= 16384) ? 65536 : int_sqrt((64'sd1 << 61) / ((64'sd1 << 28) + w * w));
        bl = p > 0 ? balance_cos(p) : 65536;
        br = p < 0 ? balance_cos(-p) : 65536;
        lo = round_sh(round_sh(lo * comp, 16) * bl, 16);
        ro = round_sh(round_sh(ro * comp, 16) * br, 16);
        o.left = 24'(clamp24(lo));
        o.right = 24'(clamp24(ro));
        return o;
    endfunction

    // stall decision: quiet stretch has none
    function automatic bit stall_now();
        return !calm && ($urandom_range(99) < 14);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_pairs.push_back(process_pair({in_ch.left_in, in_ch.right_in}));
            end
            if (pending_pairs.size() > 0 && !stall_now()) begin
                t_pair nx;
                nx = pending_pairs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.left_in <= nx.left;
                in_ch.right_in <= nx.right;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("result with nothing expected: %0d %0d",
                           out_ch.left_out, out_ch.right_out);
                    errors++;
                end else begin
                    t_pair e;
                    e = expected_pairs.pop_front();
                    n_checked++;
                    if (e.left !== out_ch.left_out) begin
                        $error("left_out expected %0d actual %0d", e.left, out_ch.left_out);
                        errors++;
                    end
                    if (e.right !== out_ch.right_out) begin
                        $error("right_out expected %0d actual %0d", e.right, out_ch.right_out);
                        errors++;
                    end
                end
            end
            out_ch.ready <= !stall_now();
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(int idx, logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx * 4);
        pwdata <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_write(idx, val);
    endtask

    // let all queued pairs finish before touching registers, sampled mid-cycle
    task automatic drain();
        @(negedge i_clk);
        while (pending_pairs.size() > 0 || in_ch.valid || expected_pairs.size() > 0)
            @(negedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_pair rand_pair();
        t_pair p;
        p.left = 24'($urandom);
        p.right = 24'($urandom);
        return p;
    endfunction

    task automatic push_pairs(int n);
        for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
    endtask

    initial begin
        t_pair dp;
        int    lens[3];
        in_ch.valid = 1'b0;
        in_ch.left_in = '0;
        in_ch.right_in = '0;
        out_ch.ready = 1'b0;
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at reset settings
        calm = 1'b1;
        dp = '{24'sh7fffff, 24'sh7fffff};  pending_pairs.push_back(dp);
        dp = '{24'sh800000, 24'sh800000};  pending_pairs.push_back(dp);
        dp = '{24'sh7fffff, 24'sh800000};  pending_pairs.push_back(dp);
        dp = '{24'sh000000, 24'shffffff};  pending_pairs.push_back(dp);
        dp = '{24'sh000001, 24'sh000000};  pending_pairs.push_back(dp);
        drain();

        // immediate jumps: max gain, full right, max width
        reg_write(REG_GAIN_LEN, 16'd0);
        reg_write(REG_PAN_LEN, 16'd0);
        reg_write(REG_WIDTH_LEN, 16'd0);
        reg_write(REG_GAIN_TGT, 16'hffff);
        reg_write(REG_PAN_TGT, 16'h4000);
        reg_write(REG_WIDTH_TGT, 16'hffff);
        dp = '{24'sh7fffff, 24'sh800000};  pending_pairs.push_back(dp);
        dp = '{24'sh400000, 24'sh123456};  pending_pairs.push_back(dp);
        push_pairs(3);
        drain();
        // full left, zero width, pan clamp from below
        reg_write(REG_PAN_TGT, 16'h8000);
        reg_write(REG_WIDTH_TGT, 16'd0);
        push_pairs(4);
        drain();
        // mute: gain target zero
        reg_write(REG_GAIN_TGT, 16'd0);
        push_pairs(3);
        drain();
        // gain target one, rewrite of same target does nothing
        reg_write(REG_GAIN_TGT, 16'd1);
        reg_write(REG_GAIN_TGT, 16'd1);
        push_pairs(3);
        drain();
        calm = 1'b0;

        // random phases with short ramps, plus one phase of maximal and one of unit length
        for (int ph = 0; ph < 16; ph++) begin
            for (int r = 0; r < 3; r++) lens[r] = $urandom_range(0, 3) == 0 ? 0 :
                                                  $urandom_range(1, 60);
            if (ph == 5) lens = '{65535, 65535, 65535};
            if (ph == 6) lens = '{1, 1, 1};
            reg_write(REG_GAIN_LEN, 16'(lens[0]));
            reg_write(REG_PAN_LEN, 16'(lens[1]));
            reg_write(REG_WIDTH_LEN, 16'(lens[2]));
            reg_write(REG_GAIN_TGT, ph == 3 ? 16'd0 : 16'($urandom_range(0, 40000)));
            reg_write(REG_PAN_TGT, 16'($urandom));
            reg_write(REG_WIDTH_TGT, 16'($urandom_range(0, 40000)));
            calm = (ph == 8);
            push_pairs(48);
            drain();
        end
        calm = 1'b0;

        $display("checked %0d output pairs over directed extremes and 16 ramp phases",
                 n_checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
sv/sgwb_pkg.sv
sv/sgwb_in_if.sv
sv/sgwb_out_if.sv
sv/stereo_gain_width_balance_core.sv
tb/sgwb_tb_if.sv
tb/tb_stereo_gain_width_balance_core.sv
